// ----- design/yuyv_pkg.sv -----
// shared types and constants for the yuyv to rgb888 converter
// no dependencies; imported by the chroma stage, the pixel lanes and the top level
package yuyv_pkg;

  localparam int COEF_W = 14;
  localparam int FRAC_W = 12;
  localparam int PROD_W = 22;
  localparam int SUM_W  = 24;
  localparam int CFG_INDEX_W = 4;

  localparam logic [COEF_W-1:0] RESET_RED_V   = 14'd5743;
  localparam logic [COEF_W-1:0] RESET_GREEN_U = 14'd1409;
  localparam logic [COEF_W-1:0] RESET_GREEN_V = 14'd2925;
  localparam logic [COEF_W-1:0] RESET_BLUE_U  = 14'd7258;

  localparam logic [CFG_INDEX_W-1:0] REG_RED_V   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_U = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_V = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_U  = 4'd3;

  typedef struct packed {
    logic [COEF_W-1:0] red_v;
    logic [COEF_W-1:0] green_u;
    logic [COEF_W-1:0] green_v;
    logic [COEF_W-1:0] blue_u;
  } coef_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] red_v;
    logic signed [PROD_W-1:0] green_u;
    logic signed [PROD_W-1:0] green_v;
    logic signed [PROD_W-1:0] blue_u;
  } prod_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ----- design/yuyv_chroma.sv -----
// shared chroma products: the four gain times offset-chroma multiplies, registered
// depends on yuyv_pkg
module yuyv_chroma (
  input  logic              clk,
  input  logic              en,
  input  logic [7:0]        chroma_blue,
  input  logic [7:0]        chroma_red,
  input  yuyv_pkg::coef_t   coef,
  output yuyv_pkg::prod_t   prod
);
  import yuyv_pkg::*;

  logic signed [7:0] cb;
  logic signed [7:0] cr;

  // minus 128 on a byte is just the top bit flipped
  assign cb = $signed({~chroma_blue[7], chroma_blue[6:0]});
  assign cr = $signed({~chroma_red[7], chroma_red[6:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      prod.red_v   <= PROD_W'(cr * $signed({1'b0, coef.red_v}));
      prod.green_u <= PROD_W'(cb * $signed({1'b0, coef.green_u}));
      prod.green_v <= PROD_W'(cr * $signed({1'b0, coef.green_v}));
      prod.blue_u  <= PROD_W'(cb * $signed({1'b0, coef.blue_u}));
    end
  end

endmodule

// ----- design/yuyv_lane.sv -----
// one pixel lane: combines scaled luma with the chroma products, floors and clamps
// depends on yuyv_pkg
module yuyv_lane (
  input  logic              clk,
  input  logic              en,
  input  logic [7:0]        luma,
  input  yuyv_pkg::prod_t   prod,
  output yuyv_pkg::rgb_t    rgb
);
  import yuyv_pkg::*;

  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sum_red;
  logic signed [SUM_W-1:0] sum_green;
  logic signed [SUM_W-1:0] sum_blue;

  // floor by dropping the fraction, then saturate to a byte
  function automatic logic [7:0] clamp_pixel(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-FRAC_W-1:0] whole;
    whole = s[SUM_W-1:FRAC_W];
    if (s[SUM_W-1]) begin
      clamp_pixel = 8'd0;
    end else if (|whole[SUM_W-FRAC_W-1:8]) begin
      clamp_pixel = 8'hFF;
    end else begin
      clamp_pixel = whole[7:0];
    end
  endfunction

  assign base      = $signed({{(SUM_W-FRAC_W-8){1'b0}}, luma, {FRAC_W{1'b0}}});
  assign sum_red   = base + SUM_W'(prod.red_v);
  assign sum_green = base - SUM_W'(prod.green_u) - SUM_W'(prod.green_v);
  assign sum_blue  = base + SUM_W'(prod.blue_u);

  always_ff @(posedge clk) begin
    if (en) begin
      rgb.red   <= clamp_pixel(sum_red);
      rgb.green <= clamp_pixel(sum_green);
      rgb.blue  <= clamp_pixel(sum_blue);
    end
  end

endmodule

// ----- design/yuyv_to_rgb888_converter.sv -----
// yuyv to rgb888 converter (bt.601, q2.12 gains): one yuyv word in, two rgb888 pixels out
// pipeline: multiply stage, then lane stage, from input transaction to output valid
// throughput: one pixel pair per clock; each stage advances when it is empty or the next moves
// reset (rst, synchronous): pipeline emptied, gains return to 1.402, 0.344, 0.714, 1.772
// depends on yuyv_pkg, yuyv_chroma and yuyv_lane
module yuyv_to_rgb888_converter (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // fields from bit 0: luma_first, chroma_blue, luma_second, chroma_red
  input  logic [31:0]                        s_tdata,
  input  logic                               s_tlast,
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // fields from bit 0: red_first, green_first, blue_first,
  // red_second, green_second, blue_second
  output logic [47:0]                        m_tdata,
  output logic                               m_tlast,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [yuyv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [yuyv_pkg::COEF_W-1:0]        cfg_data
);
  import yuyv_pkg::*;

  coef_t coef;
  prod_t prod;
  rgb_t  rgb_first;
  rgb_t  rgb_second;

  // stage 1 holds products plus delayed luma and frame end
  logic       stage1_valid;
  logic [7:0] luma_first_q;
  logic [7:0] luma_second_q;
  logic       last_q;
  // stage 2 is the output register
  logic       stage2_valid;
  logic       last_out;

  logic adv1;
  logic adv2;

  // a stage may load when it is empty or its content moves on this cycle
  assign adv2     = !stage2_valid || m_tready;
  assign adv1     = !stage1_valid || adv2;
  assign s_tready = adv1;

  // gain registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.red_v   <= RESET_RED_V;
      coef.green_u <= RESET_GREEN_U;
      coef.green_v <= RESET_GREEN_V;
      coef.blue_u  <= RESET_BLUE_U;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED_V:   coef.red_v   <= cfg_data;
        REG_GREEN_U: coef.green_u <= cfg_data;
        REG_GREEN_V: coef.green_v <= cfg_data;
        REG_BLUE_U:  coef.blue_u  <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits for the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      stage2_valid <= 1'b0;
    end else begin
      if (adv1) begin
        stage1_valid <= s_tvalid;
      end
      if (adv2) begin
        stage2_valid <= stage1_valid;
      end
    end
  end

  // payload carried alongside the multiply stage, and frame end into the output stage
  always_ff @(posedge clk) begin
    if (adv1) begin
      luma_first_q  <= s_tdata[7:0];
      luma_second_q <= s_tdata[23:16];
      last_q        <= s_tlast;
    end
    if (adv2) begin
      last_out <= last_q;
    end
  end

  // chroma products are shared by both pixels of the pair
  yuyv_chroma u_chroma (
    .clk         (clk),
    .en          (adv1),
    .chroma_blue (s_tdata[15:8]),
    .chroma_red  (s_tdata[31:24]),
    .coef        (coef),
    .prod        (prod)
  );

  // one lane per pixel, each with its own luma
  yuyv_lane u_lane_first (
    .clk  (clk),
    .en   (adv2),
    .luma (luma_first_q),
    .prod (prod),
    .rgb  (rgb_first)
  );

  yuyv_lane u_lane_second (
    .clk  (clk),
    .en   (adv2),
    .luma (luma_second_q),
    .prod (prod),
    .rgb  (rgb_second)
  );

  // merge both lanes into the output word
  assign m_tvalid = stage2_valid;
  assign m_tlast  = last_out;
  assign m_tdata  = {rgb_second.blue, rgb_second.green, rgb_second.red,
                     rgb_first.blue, rgb_first.green, rgb_first.red};

`ifndef SYNTH
  // an accepted transaction always lands in stage 1
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> stage1_valid)
    else $error("accepted transaction lost before stage 1");

  // a full stage 1 moving forward fills the output register
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (stage1_valid && adv2) |=> m_tvalid)
    else $error("stage 1 content lost on the way to the output");

  // output drains when taken and nothing follows
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !stage1_valid) |=> !m_tvalid)
    else $error("output transaction repeated");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !stage1_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- test/yuyv_pair_checker.sv -----
`timescale 1ns / 100ps
// checker for the yuyv to rgb888 converter: follows the gain writes, predicts each pixel pair
// from the input transactions and compares the output transactions field by field
// depends on yuyv_pkg for the gain widths, reset values and register indexes
module yuyv_pair_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [31:0]                      s_tdata,
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [47:0]                      m_tdata,
  input  logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [yuyv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [yuyv_pkg::COEF_W-1:0]      cfg_data,
  output int                               mismatch_count,
  output int                               pairs_pending
);
  import yuyv_pkg::*;

  typedef struct packed {
    rgb_t first;
    rgb_t second;
    logic last;
  } pixel_pair_t;

  coef_t       gains;
  pixel_pair_t pairs_due[$];

  initial begin
    mismatch_count = 0;
    pairs_pending  = 0;
  end

  // floor of a q.12 sum, then saturate to one byte
  function automatic logic [7:0] floor_clamp(int q12);
    int whole;
    whole = q12 >>> FRAC_W;
    if (whole < 0) return 8'd0;
    if (whole > 255) return 8'd255;
    return whole[7:0];
  endfunction

  function automatic rgb_t convert_pixel(logic [7:0] luma, int cb, int cr);
    int   base;
    rgb_t px;
    base     = int'(luma) <<< FRAC_W;
    px.red   = floor_clamp(base + int'(gains.red_v) * cr);
    px.green = floor_clamp(base - int'(gains.green_u) * cb - int'(gains.green_v) * cr);
    px.blue  = floor_clamp(base + int'(gains.blue_u) * cb);
    return px;
  endfunction

  function automatic pixel_pair_t predict_pair(logic [31:0] word, logic last);
    pixel_pair_t pair;
    int          cb;
    int          cr;
    cb          = int'(word[15:8]) - 128;
    cr          = int'(word[31:24]) - 128;
    pair.first  = convert_pixel(word[7:0], cb, cr);
    pair.second = convert_pixel(word[23:16], cb, cr);
    pair.last   = last;
    return pair;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_pair_t want;
    pixel_pair_t got;
    if (rst) begin
      gains.red_v   = RESET_RED_V;
      gains.green_u = RESET_GREEN_U;
      gains.green_v = RESET_GREEN_V;
      gains.blue_u  = RESET_BLUE_U;
      pairs_due.delete();
    end else begin
      // writes to indexes past the last gain are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_RED_V:   gains.red_v   = cfg_data;
          REG_GREEN_U: gains.green_u = cfg_data;
          REG_GREEN_V: gains.green_v = cfg_data;
          REG_BLUE_U:  gains.blue_u  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) pairs_due.push_back(predict_pair(s_tdata, s_tlast));
      if (m_tvalid && m_tready) begin
        got.first.red    = m_tdata[7:0];
        got.first.green  = m_tdata[15:8];
        got.first.blue   = m_tdata[23:16];
        got.second.red   = m_tdata[31:24];
        got.second.green = m_tdata[39:32];
        got.second.blue  = m_tdata[47:40];
        got.last         = m_tlast;
        if (pairs_due.size() == 0) begin
          $error("output transaction with no pixel pair due");
          mismatch_count++;
        end else begin
          want = pairs_due.pop_front();
          check_field("red_first", want.first.red, got.first.red);
          check_field("green_first", want.first.green, got.first.green);
          check_field("blue_first", want.first.blue, got.first.blue);
          check_field("red_second", want.second.red, got.second.red);
          check_field("green_second", want.second.green, got.second.green);
          check_field("blue_second", want.second.blue, got.second.blue);
          check_field("frame_end_out", 8'(want.last), 8'(got.last));
        end
      end
    end
    pairs_pending = pairs_due.size();
  end

endmodule

// ----- test/tb_yuyv_to_rgb888_converter.sv -----
`timescale 1ns / 100ps
// top of the yuyv to rgb888 converter testbench: clock, reset, gain writes and both stream sides
// depends on yuyv_pkg, the converter and yuyv_pair_checker, which predicts and compares
module tb_yuyv_to_rgb888_converter;
  import yuyv_pkg::*;

  // longest run of cycles with no transaction on either side before giving up
  localparam int WATCHDOG_LIMIT = 1000;
  // random pixel pairs per gain setting
  localparam int PAIRS_PER_PHASE = 130;
  localparam int GAIN_MAX = (1 << COEF_W) - 1;
  localparam int INDEX_MAX = (1 << CFG_INDEX_W) - 1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // fields from bit 0: luma_first, chroma_blue, luma_second, chroma_red
  logic [31:0]            s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // fields from bit 0: red_first, green_first, blue_first, red_second, green_second, blue_second
  logic [47:0]            m_tdata;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_RED_V;
  logic [COEF_W-1:0]      cfg_data = '0;

  int mismatch_count;
  int pairs_pending;
  int idle_cycles = 0;
  // when set, neither side inserts gaps: back-to-back transactions
  bit no_gaps = 1'b0;

  yuyv_to_rgb888_converter dut (.*);

  yuyv_pair_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: any transaction on either side restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_yuyv_to_rgb888_converter: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver side: a random stall before each output transaction
  initial begin
    int gap;
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // one pixel pair on the input stream, after a random gap; returns at the accepting edge
  task automatic send_pair(logic [7:0] y0, logic [7:0] u, logic [7:0] y1, logic [7:0] v,
                           logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {v, y1, u, y0};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending, wait for every pixel pair to come out, then let the pipeline settle
  task automatic drain(int settle);
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pairs_pending == 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_gain(logic [CFG_INDEX_W-1:0] index, logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // all four gains, plus a stray write past the last register that must be dropped
  task automatic load_gains(int red_v, int green_u, int green_v, int blue_u);
    write_gain(REG_RED_V, COEF_W'(red_v));
    write_gain(REG_GREEN_U, COEF_W'(green_u));
    write_gain(REG_GREEN_V, COEF_W'(green_v));
    write_gain(REG_BLUE_U, COEF_W'(blue_u));
    write_gain(CFG_INDEX_W'($urandom_range(int'(REG_BLUE_U) + 1, INDEX_MAX)),
               COEF_W'($urandom_range(0, GAIN_MAX)));
  endtask

  // bytes leaning toward the saturation corners and the chroma midpoint
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pairs under the reset gains
    send_pair(8'd0, 8'd128, 8'd255, 8'd128, 1'b0);    // black and white, no chroma
    send_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);          // all low: clamps below zero
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);  // all high: clamps above 255
    send_pair(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
    send_pair(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    send_pair(8'd128, 8'd255, 8'd128, 8'd0, 1'b1);
    send_pair(8'd128, 8'd0, 8'd128, 8'd255, 1'b0);
    send_pair(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);   // video range luma
    send_pair(8'd81, 8'd90, 8'd82, 8'd240, 1'b0);     // saturated red
    send_pair(8'd145, 8'd54, 8'd144, 8'd34, 1'b0);    // saturated green
    send_pair(8'd41, 8'd240, 8'd40, 8'd110, 1'b1);    // saturated blue
    send_pair(8'd1, 8'd127, 8'd254, 8'd129, 1'b0);    // one step off the midpoint
    send_pair(8'd254, 8'd1, 8'd1, 8'd254, 1'b0);
    send_pair(8'd170, 8'd85, 8'd85, 8'd170, 1'b0);    // alternating bit patterns
    send_pair(8'd85, 8'd170, 8'd170, 8'd85, 1'b1);
    send_pair(8'd200, 8'd128, 8'd50, 8'd255, 1'b0);
    send_pair(8'd50, 8'd255, 8'd200, 8'd128, 1'b1);

    // gain settings: zeros, all max, reset values, odd extremes, then random ones
    for (int phase = 0; phase < 7; phase++) begin
      drain(4);
      case (phase)
        0: load_gains(0, 0, 0, 0);
        1: load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        2: load_gains(int'(RESET_RED_V), int'(RESET_GREEN_U), int'(RESET_GREEN_V),
                      int'(RESET_BLUE_U));
        3: load_gains(GAIN_MAX, 0, GAIN_MAX, 0);
        default: load_gains($urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                            $urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX));
      endcase
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        // every few dozen pairs, maybe switch to a back-to-back stretch
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                  $urandom_range(0, 15) == 0);
      end
      no_gaps = 1'b0;
    end

    drain(10);
    if (mismatch_count == 0 && pairs_pending == 0) begin
      $display("tb_yuyv_to_rgb888_converter: clean");
    end else begin
      $display("tb_yuyv_to_rgb888_converter: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/yuyv_pkg.sv
design/yuyv_chroma.sv
design/yuyv_lane.sv
design/yuyv_to_rgb888_converter.sv
test/yuyv_pair_checker.sv
test/tb_yuyv_to_rgb888_converter.sv
